// ===== hdl/psu_pkg.sv =====
// Shared types, constants and register codes for the PNG scanline unfilter.
// No dependencies; imported by the top level, psu_regs and psu_predict.
package psu_pkg;

    // Line store geometry
    localparam int MAX_ROW_BYTES = 16384;
    localparam int COL_W         = $clog2(MAX_ROW_BYTES);
    localparam int ROW_W         = 15;
    localparam int BPP_W         = 3;

    // Configuration port
    localparam int ADDR_W        = 3;
    localparam int DATA_W        = 32;
    localparam logic REG_BPP       = 1'b0;
    localparam logic REG_ROW_BYTES = 1'b1;

    // Filter types
    localparam logic [2:0] FILT_NONE  = 3'd0;
    localparam logic [2:0] FILT_SUB   = 3'd1;
    localparam logic [2:0] FILT_UP    = 3'd2;
    localparam logic [2:0] FILT_AVG   = 3'd3;
    localparam logic [2:0] FILT_PAETH = 3'd4;

    typedef struct packed {
        logic [BPP_W-1:0] bpp;
        logic [ROW_W-1:0] row_bytes;
    } t_cfg;

    // One byte travelling from the front stage to the reconstruct stage
    typedef struct packed {
        logic             is_filter;
        logic [7:0]       data_byte;
        logic [2:0]       filt;
        logic [1:0]       bpp_sel;
        logic             has_left;
        logic             first_row;
        logic             last;
        logic [COL_W-1:0] col;
    } t_item;

endpackage

// ===== hdl/png_scanline_unfilter.sv =====
// Top level of the PNG scanline unfilter: front stage, line store, output register.
// Depends on psu_pkg, psu_ram, psu_regs and psu_predict.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+-------------------------------------
//  s_axis   | in        | s_axis_tvalid/tready   | tdata[7:0] stream_byte, tuser[0] image_start
//  m_axis   | out       | m_axis_tvalid/tready   | tdata[7:0] pixel_byte, tlast row_end
//  apb      | in        | psel/penable/pready    | 0x0 bytes_per_pixel, 0x4 row_bytes
//
// One byte per cycle sustained while m_axis accepts; a data byte taken goes through the
// line store read, then is reconstructed into the output register that drives m_axis.
// Filter bytes produce no transaction and pass through the reconstruct stage.
// The line store is one 16384 x 8 RAM: read at the front stage, written back at
// the reconstruct stage. No clearing pass after reset; the store is written as rows go.
// A stall on m_axis holds the reconstruct stage and the RAM read data in place.
module png_scanline_unfilter import psu_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [7:0] stream_byte
    input  logic [0:0]        s_axis_tuser,   // [0] image_start
    // output stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata,   // [7:0] pixel_byte
    output logic              m_axis_tlast,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg             cfg;
    logic             s_acc;
    logic             start;
    logic             await_eff;
    logic [BPP_W-1:0] bpp_eff;
    logic [ROW_W-1:0] rb_eff;
    logic [ROW_W-1:0] col_ext;
    logic [ROW_W-1:0] col_inc;
    logic             last;
    logic             s1_adv;
    logic             ram_re;
    logic             ram_we;
    logic [7:0]       prior;
    logic [7:0]       pixel;
    t_item            n_item;

    // Front-stage row state
    logic             r_await;
    logic             r_first;
    logic [COL_W-1:0] r_col;
    logic [2:0]       r_filter;
    // Reconstruct stage
    logic             r_s1_valid;
    t_item            r_s1;
    // Output register
    logic             r_out_valid;
    logic [7:0]       r_out_pix;
    logic             r_out_last;

    psu_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Handshake: reconstruct stage retires when a filter byte, or when the output slot frees
    assign s1_adv = r_s1_valid && (r_s1.is_filter || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_adv;
    assign s_acc = s_axis_tvalid && s_axis_tready;

    // Clamp register values into range
    always_comb begin
        if (cfg.bpp == BPP_W'(0)) begin
            bpp_eff = BPP_W'(1);
        end else if (cfg.bpp > BPP_W'(4)) begin
            bpp_eff = BPP_W'(4);
        end else begin
            bpp_eff = cfg.bpp;
        end
        if (cfg.row_bytes == ROW_W'(0)) begin
            rb_eff = ROW_W'(1);
        end else if (cfg.row_bytes > ROW_W'(MAX_ROW_BYTES)) begin
            rb_eff = ROW_W'(MAX_ROW_BYTES);
        end else begin
            rb_eff = cfg.row_bytes;
        end
    end

    // Front stage decode
    assign start     = s_axis_tuser[0];
    assign await_eff = r_await || start;
    assign col_ext   = ROW_W'(r_col);
    assign col_inc   = col_ext + ROW_W'(1);
    assign last      = (col_inc >= rb_eff);

    always_comb begin
        n_item.is_filter = await_eff;
        n_item.data_byte = s_axis_tdata;
        n_item.filt      = r_filter;
        n_item.bpp_sel   = 2'(bpp_eff - BPP_W'(1));
        n_item.has_left  = (col_ext >= ROW_W'(bpp_eff));
        n_item.first_row = r_first;
        n_item.last      = last;
        n_item.col       = r_col;
    end

    // Row position, filter type and first-row tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_await  <= 1'b1;
            r_first  <= 1'b1;
            r_col    <= '0;
            r_filter <= FILT_NONE;
        end else if (s_acc) begin
            if (await_eff) begin
                r_filter <= (s_axis_tdata > 8'd4) ? FILT_NONE : s_axis_tdata[2:0];
                r_col    <= '0;
                r_await  <= 1'b0;
                r_first  <= r_first || start;
            end else if (last) begin
                r_col   <= '0;
                r_await <= 1'b1;
                r_first <= 1'b0;
            end else begin
                r_col <= COL_W'(col_inc);
            end
        end
    end

    // Reconstruct stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_s1 <= n_item;
        end
    end

    // Line store: read the prior-row byte up front, write the new byte back on retire.
    // Consecutive data bytes use different columns, and a stalled byte blocks new reads.
    assign ram_re = s_acc && !await_eff;
    assign ram_we = s1_adv && !r_s1.is_filter;

    psu_ram #(
        .WIDTH (8),
        .DEPTH (MAX_ROW_BYTES)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s1.col),
        .i_wdata (pixel),
        .i_re    (ram_re),
        .i_raddr (r_col),
        .o_rdata (prior)
    );

    psu_predict u_predict (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (r_s1),
        .i_retire (s1_adv),
        .i_prior  (prior),
        .o_pixel  (pixel)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ram_we) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ram_we) begin
            r_out_pix  <= pixel;
            r_out_last <= r_s1.last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_pix;
    assign m_axis_tlast  = r_out_last;

    // Checks
    a_no_same_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && ram_re) |-> (r_s1.col != r_col))
        else $error("line store read and write hit the same column");

    a_stall_holds_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |-> !ram_re)
        else $error("line store read issued while reconstruct stage stalled");

    a_await_col_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_await |-> (r_col == '0))
        else $error("column not zero while waiting for a filter byte");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |-> !ram_we)
        else $error("output register overwritten while stalled");

endmodule

// ===== hdl/psu_ram.sv =====
// Generic single-clock RAM, one write port and one read port, registered read.
// Read data holds while the read enable is low. No dependencies.
module psu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/psu_regs.sv =====
// Configuration registers behind an APB-style port: pixel size and row length.
// Depends on psu_pkg.
module psu_regs import psu_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [BPP_W-1:0] r_bpp;
    logic [ROW_W-1:0] r_row_bytes;
    logic             wr_en;
    logic             reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp       <= BPP_W'(1);
            r_row_bytes <= ROW_W'(1);
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_BPP:       r_bpp       <= pwdata[BPP_W-1:0];
                REG_ROW_BYTES: r_row_bytes <= pwdata[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (reg_sel)
            REG_BPP:       prdata = {{(DATA_W-BPP_W){1'b0}}, r_bpp};
            REG_ROW_BYTES: prdata = {{(DATA_W-ROW_W){1'b0}}, r_row_bytes};
            default:       prdata = '0;
        endcase
    end

    assign o_cfg.bpp       = r_bpp;
    assign o_cfg.row_bytes = r_row_bytes;

endmodule

// ===== hdl/psu_predict.sv =====
// Reconstruct stage: neighbor history, filter predictor and the final add.
// Depends on psu_pkg; prior-row byte comes from the line store read port.
module psu_predict import psu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_item      i_item,
    input  logic       i_retire,
    input  logic [7:0] i_prior,
    output logic [7:0] o_pixel
);

    logic [7:0] r_left [4];
    logic [7:0] r_uleft [4];
    logic [7:0] a, b, c, pred;
    logic [8:0] avg_sum;
    logic signed [9:0] pa, pb, pc;
    logic signed [9:0] da, db, dc;

    // Neighbors; zero near row start and on the first row
    assign a = i_item.has_left ? r_left[i_item.bpp_sel] : 8'd0;
    assign b = i_item.first_row ? 8'd0 : i_prior;
    assign c = (i_item.has_left && !i_item.first_row) ? r_uleft[i_item.bpp_sel] : 8'd0;

    // Paeth distances: |p-a| = |b-c|, |p-b| = |a-c|, |p-c| = |a+b-2c|
    assign da = $signed({2'b00, b}) - $signed({2'b00, c});
    assign db = $signed({2'b00, a}) - $signed({2'b00, c});
    assign dc = da + db;
    assign pa = (da < 0) ? -da : da;
    assign pb = (db < 0) ? -db : db;
    assign pc = (dc < 0) ? -dc : dc;

    assign avg_sum = {1'b0, a} + {1'b0, b};

    always_comb begin
        case (i_item.filt)
            FILT_SUB:   pred = a;
            FILT_UP:    pred = b;
            FILT_AVG:   pred = avg_sum[8:1];
            FILT_PAETH: begin
                if (pa <= pb && pa <= pc) begin
                    pred = a;
                end else if (pb <= pc) begin
                    pred = b;
                end else begin
                    pred = c;
                end
            end
            default:    pred = 8'd0;
        endcase
    end

    assign o_pixel = i_item.data_byte + pred;

    // History shift on each retired data byte, cleared by a filter byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_left[i]  <= 8'd0;
                r_uleft[i] <= 8'd0;
            end
        end else if (i_retire) begin
            if (i_item.is_filter) begin
                for (int i = 0; i < 4; i++) begin
                    r_left[i]  <= 8'd0;
                    r_uleft[i] <= 8'd0;
                end
            end else begin
                for (int i = 1; i < 4; i++) begin
                    r_left[i]  <= r_left[i-1];
                    r_uleft[i] <= r_uleft[i-1];
                end
                r_left[0]  <= o_pixel;
                r_uleft[0] <= b;
            end
        end
    end

endmodule

// ===== verif/tb_png_scanline_unfilter.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for png_scanline_unfilter: stream driver, output monitor
// and an in-bench scanline reconstruction model. Depends on psu_pkg and the top level.
module tb_png_scanline_unfilter;
    import psu_pkg::*;

    localparam int CYCLE_LIMIT   = 4_000_000;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 120;

    typedef struct packed {
        logic [7:0] sbyte;
        logic       img_start;
    } t_stream_item;

    typedef struct packed {
        logic [7:0] pix;
        logic       eol;
    } t_pixel;

    typedef enum logic [1:0] { RX_OPEN, RX_HALF, RX_SLOW, RX_BEAT } t_rx_mode;

    // DUT ports
    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata  = '0;   // [7:0] stream_byte
    logic [0:0]        s_axis_tuser  = '0;   // [0] image_start
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [7:0]        m_axis_tdata;         // [7:0] pixel_byte
    logic              m_axis_tlast;
    logic              psel          = 1'b0;
    logic              penable       = 1'b0;
    logic              pwrite        = 1'b0;
    logic [ADDR_W-1:0] paddr         = '0;
    logic [DATA_W-1:0] pwdata        = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // Stimulus and expected pixels
    t_stream_item stream_q[$];
    t_pixel       pixel_q[$];
    int           err_cnt   = 0;
    int           cycle_cnt = 0;

    // Model state: registers, line store, neighbour history, row position
    logic [BPP_W-1:0] cfg_bpp  = BPP_W'(1);
    logic [ROW_W-1:0] cfg_rows = ROW_W'(1);
    logic [7:0]       line_mem [MAX_ROW_BYTES];
    logic [3:0][7:0]  left_hist   = '0;
    logic [3:0][7:0]  upleft_hist = '0;
    int               col_pos     = 0;
    logic [2:0]       row_filt    = FILT_NONE;
    logic             first_row   = 1'b1;
    logic             want_filter = 1'b1;

    png_scanline_unfilter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #1 i_clk = ~i_clk;

    // Paeth predictor: nearest of a, b, c to a + b - c, ties go a, then b
    function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
        int p, pa, pb, pc;
        p  = int'(a) + int'(b) - int'(c);
        pa = (p > int'(a)) ? p - int'(a) : int'(a) - p;
        pb = (p > int'(b)) ? p - int'(b) : int'(b) - p;
        pc = (p > int'(c)) ? p - int'(c) : int'(c) - p;
        if (pa <= pb && pa <= pc) return a;
        if (pb <= pc) return b;
        return c;
    endfunction

    function automatic int eff_rows();
        if (cfg_rows == 0) return 1;
        if (cfg_rows > MAX_ROW_BYTES) return MAX_ROW_BYTES;
        return int'(cfg_rows);
    endfunction

    // Reconstruct one stream byte; returns 1 when it yields a pixel byte
    function automatic bit unfilter_byte(input logic [7:0] in_byte, input logic start,
                                         output logic [7:0] pix, output logic eol);
        int         bpp, rows, x;
        logic [7:0] a, b, c;
        logic [8:0] pred;
        pix = '0;
        eol = 1'b0;
        if (start) begin
            first_row   = 1'b1;
            want_filter = 1'b1;
        end
        // filter byte: latch the row's filter, clear the neighbours
        if (want_filter) begin
            row_filt    = (in_byte > 8'd4) ? FILT_NONE : in_byte[2:0];
            col_pos     = 0;
            left_hist   = '0;
            upleft_hist = '0;
            want_filter = 1'b0;
            return 1'b0;
        end
        bpp  = (cfg_bpp == 0) ? 1 : (cfg_bpp > 4) ? 4 : int'(cfg_bpp);
        rows = eff_rows();
        x    = (col_pos >= MAX_ROW_BYTES) ? MAX_ROW_BYTES - 1 : col_pos;
        a = (x >= bpp) ? left_hist[bpp-1] : 8'h00;
        b = first_row ? 8'h00 : line_mem[x];
        c = (x >= bpp && !first_row) ? upleft_hist[bpp-1] : 8'h00;
        case (row_filt)
            FILT_SUB:   pred = {1'b0, a};
            FILT_UP:    pred = {1'b0, b};
            FILT_AVG:   pred = ({1'b0, a} + {1'b0, b}) >> 1;
            FILT_PAETH: pred = {1'b0, paeth_pick(a, b, c)};
            default:    pred = '0;
        endcase
        pix         = in_byte + pred[7:0];
        line_mem[x] = pix;
        left_hist   = {left_hist[2:0], pix};
        upleft_hist = {upleft_hist[2:0], b};
        eol = (x + 1 >= rows);
        if (eol) begin
            col_pos     = 0;
            want_filter = 1'b1;
            first_row   = 1'b0;
        end else begin
            col_pos = x + 1;
        end
        return 1'b1;
    endfunction

    // Sender: bursts of random length, random gaps, occasional long unbroken runs
    int           burst_left = 0;
    int           gap_left   = 0;
    t_stream_item nxt_item;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (stream_q.size() > 0) begin
                nxt_item = stream_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= nxt_item.sbyte;
                s_axis_tuser  <= nxt_item.img_start;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 256)
                                                             : $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern switches at random among open, half, slow and beat modes
    t_rx_mode   rx_mode   = RX_OPEN;
    int         rx_left   = 0;
    int         beat_idx  = 0;
    logic [7:0] beat_mask = 8'hFF;

    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode   = t_rx_mode'($urandom_range(0, 3));
            rx_left   = $urandom_range(20, 200);
            beat_mask = 8'($urandom) | 8'h01;
        end else begin
            rx_left--;
        end
        beat_idx = (beat_idx + 1) % 8;
        case (rx_mode)
            RX_OPEN: m_axis_tready <= 1'b1;
            RX_HALF: m_axis_tready <= 1'($urandom_range(0, 1));
            RX_SLOW: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= beat_mask[beat_idx];
        endcase
    end

    // Monitor: predict on every accepted input, check every accepted output
    logic [7:0] mon_pix;
    logic       mon_eol;
    t_pixel     want_px;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready === 1'b1) begin
                if (unfilter_byte(s_axis_tdata, s_axis_tuser[0], mon_pix, mon_eol))
                    pixel_q.push_back('{pix: mon_pix, eol: mon_eol});
            end
            if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
                if (pixel_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("[%0t] unexpected pixel %02h last %0b", $time,
                                 m_axis_tdata, m_axis_tlast);
                end else begin
                    want_px = pixel_q.pop_front();
                    if (m_axis_tdata !== want_px.pix || m_axis_tlast !== want_px.eol) begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display({"[%0t] pixel mismatch: expected %02h last %0b,",
                                      " got %02h last %0b"}, $time, want_px.pix,
                                     want_px.eol, m_axis_tdata, m_axis_tlast);
                    end
                end
            end
        end
    end

    // Run limit
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // Stimulus helpers
    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_filter();
        if ($urandom_range(0, 9) == 0) return 8'($urandom_range(5, 255));
        return 8'($urandom_range(FILT_NONE, FILT_PAETH));
    endfunction

    function automatic void push_stream(input logic [7:0] b, input logic s);
        stream_q.push_back('{sbyte: b, img_start: s});
    endfunction

    function automatic void queue_data(input int n);
        for (int k = 0; k < n; k++) push_stream(rand_byte(), 1'b0);
    endfunction

    function automatic void queue_row(input logic [7:0] filt, input int n, input logic s);
        push_stream(filt, s);
        queue_data(n);
    endfunction

    // One image of random rows; aborted rows are followed by a fresh image start
    function automatic int queue_image(input int n_items);
        int   rows, made, len;
        logic s;
        rows = eff_rows();
        made = 0;
        s    = 1'b1;
        while (made < n_items) begin
            len = rows;
            if ($urandom_range(0, 11) == 0) len = $urandom_range(0, rows - 1);
            if (len > n_items - made - 1) len = n_items - made - 1;
            queue_row(pick_filter(), len, s);
            made += len + 1;
            s = (len < rows) || ($urandom_range(0, 9) == 0);
        end
        return made;
    endfunction

    // Register write: setup then access; unused upper bits get random junk at times
    task automatic cfg_write(input logic reg_idx, input int unsigned value);
        logic [DATA_W-1:0] word;
        word = ($urandom_range(0, 1) == 1) ? DATA_W'($urandom) : '0;
        if (reg_idx == REG_BPP) word[BPP_W-1:0] = value[BPP_W-1:0];
        else                    word[ROW_W-1:0] = value[ROW_W-1:0];
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({reg_idx, 2'b00});
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == REG_BPP) cfg_bpp  = word[BPP_W-1:0];
        else                    cfg_rows = word[ROW_W-1:0];
    endtask

    task automatic set_config(input int unsigned bpp, input int unsigned rows);
        cfg_write(REG_BPP, bpp);
        cfg_write(REG_ROW_BYTES, rows);
        @(negedge i_clk);
    endtask

    // Wait for the stream to be consumed and all pixels back, then let the pipe settle
    task automatic drain_block();
        int waited;
        while (stream_q.size() != 0 || s_axis_tvalid) @(negedge i_clk);
        waited = 0;
        while (pixel_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        if (pixel_q.size() != 0) begin
            err_cnt += pixel_q.size();
            $display("[%0t] %0d expected pixels never arrived", $time, pixel_q.size());
            pixel_q.delete();
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Main sequence
    int unsigned corner_bpp [8] = '{0, 4, 7, 5, 2, 1, 3, 6};
    int unsigned corner_rows[8] = '{5, 16, 7, 3, 0, 1, 2, 24};

    initial begin
        int rand_items, pick, rows_sel;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset register values: one byte per row, every filter and unknown codes
        queue_row(FILT_NONE, 0, 1'b0);  push_stream(8'h00, 1'b0);
        queue_row(FILT_SUB, 0, 1'b0);   push_stream(8'hFF, 1'b0);
        queue_row(FILT_UP, 0, 1'b0);    push_stream(8'h80, 1'b0);
        queue_row(FILT_AVG, 0, 1'b0);   push_stream(8'h7F, 1'b0);
        queue_row(FILT_PAETH, 0, 1'b0); push_stream(8'h01, 1'b0);
        push_stream(8'h05, 1'b0);       push_stream(8'hAA, 1'b0);
        push_stream(8'hFF, 1'b0);       push_stream(8'h55, 1'b0);
        queue_row(FILT_UP, 0, 1'b1);    push_stream(8'h12, 1'b0);
        // image start landing where a data byte was due
        queue_row(FILT_PAETH, 0, 1'b0);
        queue_row(FILT_UP, 0, 1'b1);    push_stream(8'hFE, 1'b0);
        drain_block();

        // Row length shrinks mid-row below the current column, then grows mid-row
        set_config(3, 8);
        queue_row(FILT_SUB, 8, 1'b1);
        queue_row(FILT_PAETH, 8, 1'b0);
        queue_row(FILT_AVG, 5, 1'b0);
        drain_block();
        cfg_write(REG_ROW_BYTES, 3);
        @(negedge i_clk);
        queue_data(1);
        queue_row(FILT_UP, 3, 1'b0);
        queue_row(FILT_PAETH, 1, 1'b0);
        drain_block();
        set_config(2, 6);
        queue_data(5);
        queue_row(FILT_UP, 6, 1'b0);
        queue_row(FILT_PAETH, 6, 1'b0);
        drain_block();

        // Corner settings, out-of-range codes included
        for (int k = 0; k < 8; k++) begin
            set_config(corner_bpp[k], corner_rows[k]);
            void'(queue_image(36));
            drain_block();
        end

        // Row length register above the line store size clamps
        set_config(4, 32'h7FFF);
        void'(queue_image(30));
        drain_block();

        // Random images with random settings, mostly short rows
        rand_items = 0;
        while (rand_items < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (pick == 0)      rows_sel = 0;
            else if (pick <= 2) rows_sel = $urandom_range(25, 300);
            else                rows_sel = $urandom_range(1, 24);
            set_config($urandom_range(0, 7), rows_sel);
            rand_items += queue_image($urandom_range(20, 80));
            drain_block();
        end

        if (err_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
